[hdl/mactt_pkg.sv]
// ----------------------------------------------------------------------------
// mactt_pkg: shared types and constants of the crossover trade tracker
// item layouts, register codes, reciprocal constants for the divide by 10000
// ----------------------------------------------------------------------------
`default_nettype none

package mactt_pkg;

  // field widths
  localparam int TIME_W     = 48;
  localparam int PRICE_W    = 32;
  localparam int EQ_W       = 48;
  localparam int DD_W       = 47;
  localparam int FW_W       = 8;
  localparam int SW_W       = 9;
  localparam int BPS_W      = 14;
  localparam int BPS_SUM_W  = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  // register reset values
  localparam logic [FW_W-1:0] FAST_RESET = 8'd10;
  localparam logic [SW_W-1:0] SLOW_RESET = 9'd30;

  // one basis-point unit
  localparam int BPS_ONE = 10000;
  localparam logic [BPS_SUM_W-1:0] BPS_ONE_V = 15'd10000;

  // price split: hi = floor(px * RECIP_PX / 2^46) is exactly px / 10000
  localparam int RECIP_PX_W     = 33;
  localparam logic [RECIP_PX_W-1:0] RECIP_PX = 33'd7036874418;
  localparam int RECIP_PX_SHIFT = 46;
  localparam int PX_PROD_W      = PRICE_W + RECIP_PX_W;
  localparam int PH_W           = PX_PROD_W - RECIP_PX_SHIFT;
  localparam int PL_W           = 14;

  // remainder part: floor(w * RECIP_REM / 2^43) is exactly w / 10000, w < 2^29
  localparam int WB_W            = 29;
  localparam int RECIP_REM_W     = 30;
  localparam logic [RECIP_REM_W-1:0] RECIP_REM = 30'd879609303;
  localparam int RECIP_REM_SHIFT = 43;
  localparam int REM_PROD_W      = WB_W + RECIP_REM_W;
  localparam int QB_W            = REM_PROD_W - RECIP_REM_SHIFT;
  localparam logic [WB_W-1:0] ROUND_UP = 29'd9999;

  // quotient and cash delta widths
  localparam int QA_W    = PH_W + BPS_SUM_W;
  localparam int DELTA_W = 36;

  // saturation limits
  localparam logic signed [EQ_W-1:0] EQ_MAX = {1'b0, {(EQ_W-1){1'b1}}};
  localparam logic signed [EQ_W-1:0] EQ_MIN = {1'b1, {(EQ_W-1){1'b0}}};
  localparam logic [DD_W-1:0] DD_MAX = {DD_W{1'b1}};

  // configuration register codes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FAST_WINDOW  = 2'd0,
    CFG_SLOW_WINDOW  = 2'd1,
    CFG_FEE_BPS      = 2'd2,
    CFG_SLIPPAGE_BPS = 2'd3
  } cfg_reg_t;

  // trade decision of one bar
  typedef enum logic [1:0] {
    TRADE_NONE = 2'd0,
    TRADE_BUY  = 2'd1,
    TRADE_SELL = 2'd2
  } trade_t;

  // input item: one bar
  typedef struct packed {
    logic [TIME_W-1:0]  timestamp_ms;
    logic [PRICE_W-1:0] close_price;
  } in_item_t;

  // result item: one curve point
  typedef struct packed {
    logic [TIME_W-1:0]        point_time_ms;
    logic [PRICE_W-1:0]       point_price;
    logic signed [EQ_W-1:0]   equity;
    logic                     holding;
    logic [DD_W-1:0]          max_drawdown;
  } out_item_t;

endpackage

`default_nettype wire

[hdl/ma_crossover_trade_tracker.sv]
// ----------------------------------------------------------------------------
// ma_crossover_trade_tracker: moving-average crossover trade tracker
// price ring with fast and slow window sums, exact cross-multiplied average
// compare, one-unit long position, costed trades and running max drawdown
// ----------------------------------------------------------------------------
//
//   channel  signals                          direction  moves
//   in       in_valid in_stall in_data        input      one bar per item
//   out      out_valid out_stall out_data     output     one curve point
//   cfg      cfg_valid cfg_ready cfg_index    input      one register write
//            cfg_data
//
// one item per cycle while out_stall is low; a result passes through every
// numbered stage and the output register after its bar is accepted. the rate
// is set by the cash, position, peak and drawdown recurrences, each one wide
// add or compare in its own stage. reset is synchronous; the ring needs no
// clearing pass, so items are taken from the first cycle after reset. out_stall
// holds the output register; stages behind it fill their bubbles, and in_stall
// rises once the first stage cannot move. bars with no result end by stage 1.
//
`default_nettype none

module ma_crossover_trade_tracker #(
  parameter int MAX_WINDOW = 256
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  // bar channel
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  mactt_pkg::in_item_t                  in_data,
  // curve point channel
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output mactt_pkg::out_item_t                 out_data,
  // configuration writes
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire [mactt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire [mactt_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int AW     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int XW     = ((AW > mactt_pkg::SW_W) ? AW : mactt_pkg::SW_W) + 1;
  localparam int SUM_W  = mactt_pkg::PRICE_W + AW;
  localparam int PROD_W = SUM_W + mactt_pkg::SW_W;

  // configuration registers
  logic [mactt_pkg::FW_W-1:0]  fw_r;
  logic [mactt_pkg::SW_W-1:0]  sw_r;
  logic [mactt_pkg::BPS_W-1:0] fee_r;
  logic [mactt_pkg::BPS_W-1:0] slip_r;
  logic                        cfg_we;
  logic                        win_clear;
  logic [mactt_pkg::BPS_SUM_W-1:0] bps_sum;

  // window state
  logic [AW-1:0]               widx_r;
  logic [mactt_pkg::SW_W-1:0]  bars_seen_r;
  logic [mactt_pkg::SW_W-1:0]  bars_inc;
  logic [SUM_W-1:0]            fast_sum_r;
  logic [SUM_W-1:0]            slow_sum_r;
  logic [mactt_pkg::PRICE_W-1:0] ring [MAX_WINDOW];
  logic [mactt_pkg::PRICE_W-1:0] rd_f_r;
  logic [mactt_pkg::PRICE_W-1:0] rd_s_r;
  logic [XW-1:0]               back_f;
  logic [XW-1:0]               back_s;
  logic [AW-1:0]               addr_f;
  logic [AW-1:0]               addr_s;
  logic                        win_ok;
  logic                        accept;
  logic                        ring_en;

  // stage flow control
  logic [9:1] v_r;
  logic [9:1] v_nxt;
  logic [9:1] mv;
  logic       free_out;

  // stage 1
  logic [mactt_pkg::TIME_W-1:0]  s1_ts_r;
  logic [mactt_pkg::PRICE_W-1:0] s1_px_r;
  logic                          s1_use_f_r;
  logic                          s1_use_s_r;
  logic                          s1_emit_r;
  // stage 2
  logic [mactt_pkg::TIME_W-1:0]    s2_ts_r;
  logic [mactt_pkg::PRICE_W-1:0]   s2_px_r;
  logic [mactt_pkg::PH_W-1:0]      s2_ph_r;
  logic [mactt_pkg::PX_PROD_W-1:0] px_prod;
  // stage 3
  logic [mactt_pkg::TIME_W-1:0]  s3_ts_r;
  logic [mactt_pkg::PRICE_W-1:0] s3_px_r;
  logic [mactt_pkg::PH_W-1:0]    s3_ph_r;
  logic [mactt_pkg::PL_W-1:0]    s3_pl_r;
  logic [PROD_W-1:0]             s3_pf_r;
  logic [PROD_W-1:0]             s3_ps_r;
  logic [mactt_pkg::PRICE_W:0]   ph_scaled;
  logic [mactt_pkg::PRICE_W:0]   pl_full;
  // stage 4
  logic [mactt_pkg::TIME_W-1:0]  s4_ts_r;
  logic [mactt_pkg::PRICE_W-1:0] s4_px_r;
  logic                          s4_hold_r;
  mactt_pkg::trade_t             s4_trade_r;
  logic [mactt_pkg::QA_W-1:0]    s4_qa_r;
  logic [mactt_pkg::WB_W-1:0]    s4_wb_r;
  logic                          pos_r;
  logic                          pos_nxt;
  mactt_pkg::trade_t             trade_nxt;
  // stage 5
  logic [mactt_pkg::TIME_W-1:0]     s5_ts_r;
  logic [mactt_pkg::PRICE_W-1:0]    s5_px_r;
  logic                             s5_hold_r;
  mactt_pkg::trade_t                s5_trade_r;
  logic [mactt_pkg::QA_W-1:0]       s5_qa_r;
  logic [mactt_pkg::QB_W-1:0]       s5_qlo_r;
  logic [mactt_pkg::QB_W-1:0]       s5_qhi_r;
  logic [mactt_pkg::REM_PROD_W-1:0] lo_prod;
  logic [mactt_pkg::REM_PROD_W-1:0] hi_prod;
  // stage 6
  logic [mactt_pkg::TIME_W-1:0]  s6_ts_r;
  logic [mactt_pkg::PRICE_W-1:0] s6_px_r;
  logic                          s6_hold_r;
  logic [mactt_pkg::DELTA_W-1:0] s6_delta_r;
  logic [mactt_pkg::DELTA_W-1:0] delta_nxt;
  logic [mactt_pkg::DELTA_W-1:0] trade_amt;
  // stage 7
  logic [mactt_pkg::TIME_W-1:0]  s7_ts_r;
  logic [mactt_pkg::PRICE_W-1:0] s7_px_r;
  logic                          s7_hold_r;
  logic signed [mactt_pkg::EQ_W-1:0] cash_r;
  logic signed [mactt_pkg::EQ_W-1:0] cash_nxt;
  logic signed [mactt_pkg::EQ_W:0]   cash_sum;
  // stage 8
  logic [mactt_pkg::TIME_W-1:0]  s8_ts_r;
  logic [mactt_pkg::PRICE_W-1:0] s8_px_r;
  logic                          s8_hold_r;
  logic signed [mactt_pkg::EQ_W-1:0] s8_eq_r;
  logic signed [mactt_pkg::EQ_W-1:0] eq_nxt;
  logic signed [mactt_pkg::EQ_W:0]   eq_sum;
  // stage 9
  logic [mactt_pkg::TIME_W-1:0]  s9_ts_r;
  logic [mactt_pkg::PRICE_W-1:0] s9_px_r;
  logic                          s9_hold_r;
  logic signed [mactt_pkg::EQ_W-1:0] s9_eq_r;
  logic signed [mactt_pkg::EQ_W-1:0] peak_r;
  // output stage
  logic                          out_valid_r;
  mactt_pkg::out_item_t          out_data_r;
  logic [mactt_pkg::DD_W-1:0]    worst_r;
  logic [mactt_pkg::DD_W-1:0]    worst_nxt;
  logic [mactt_pkg::DD_W-1:0]    dd_clip;
  logic [mactt_pkg::EQ_W:0]      dd_full;

  // configuration port always ready
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid;
  assign win_clear = cfg_we && (cfg_index == mactt_pkg::CFG_FAST_WINDOW ||
                                cfg_index == mactt_pkg::CFG_SLOW_WINDOW);
  assign bps_sum   = mactt_pkg::BPS_SUM_W'(fee_r) + mactt_pkg::BPS_SUM_W'(slip_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r   <= mactt_pkg::FAST_RESET;
      sw_r   <= mactt_pkg::SLOW_RESET;
      fee_r  <= '0;
      slip_r <= '0;
    end else if (cfg_we) begin
      unique case (mactt_pkg::cfg_reg_t'(cfg_index))
        mactt_pkg::CFG_FAST_WINDOW:  fw_r   <= cfg_data[mactt_pkg::FW_W-1:0];
        mactt_pkg::CFG_SLOW_WINDOW:  sw_r   <= cfg_data[mactt_pkg::SW_W-1:0];
        mactt_pkg::CFG_FEE_BPS:      fee_r  <= cfg_data[mactt_pkg::BPS_W-1:0];
        mactt_pkg::CFG_SLIPPAGE_BPS: slip_r <= cfg_data[mactt_pkg::BPS_W-1:0];
      endcase
    end
  end

  // window check and ring addresses of the prices leaving each window
  always_comb begin
    win_ok = (fw_r != '0) && ({1'b0, fw_r} < sw_r) && (32'(sw_r) <= MAX_WINDOW);
    back_f = XW'(widx_r) + XW'(MAX_WINDOW) - XW'(fw_r);
    back_s = XW'(widx_r) + XW'(MAX_WINDOW) - XW'(sw_r);
    if (back_f >= XW'(MAX_WINDOW)) begin
      back_f = back_f - XW'(MAX_WINDOW);
    end
    if (back_s >= XW'(MAX_WINDOW)) begin
      back_s = back_s - XW'(MAX_WINDOW);
    end
    addr_f   = back_f[AW-1:0];
    addr_s   = back_s[AW-1:0];
    bars_inc = (bars_seen_r < sw_r) ? bars_seen_r + 9'd1 : bars_seen_r;
  end

  // stage advance chain, output side first
  always_comb begin
    free_out = !out_valid_r || !out_stall;
    mv[9]    = v_r[9] && free_out;
    for (int k = 8; k >= 2; k--) begin
      mv[k] = v_r[k] && (!v_r[k+1] || mv[k+1]);
    end
    mv[1]  = v_r[1] && (!s1_emit_r || !v_r[2] || mv[2]);
    accept = in_valid && (!v_r[1] || mv[1]);
    v_nxt[1] = (accept && win_ok) || (v_r[1] && !mv[1]);
    v_nxt[2] = (mv[1] && s1_emit_r) || (v_r[2] && !mv[2]);
    for (int k = 3; k <= 9; k++) begin
      v_nxt[k] = mv[k-1] || (v_r[k] && !mv[k]);
    end
  end

  assign in_stall = v_r[1] && !mv[1];
  assign ring_en  = accept && win_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      v_r         <= v_nxt;
      out_valid_r <= mv[9] || (out_valid_r && out_stall);
    end
  end

  // price ring, read before write
  always_ff @(posedge clk) begin
    if (ring_en) begin
      ring[widx_r] <= in_data.close_price;
      rd_f_r       <= ring[addr_f];
      rd_s_r       <= ring[addr_s];
    end
  end

  // write pointer and fill count
  always_ff @(posedge clk) begin
    if (!rst_n || win_clear) begin
      widx_r      <= '0;
      bars_seen_r <= '0;
    end else if (ring_en) begin
      widx_r      <= (widx_r == AW'(MAX_WINDOW - 1)) ? '0 : widx_r + 1'b1;
      bars_seen_r <= bars_inc;
    end
  end

  // stage 1: bar and window flags
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ts_r    <= in_data.timestamp_ms;
      s1_px_r    <= in_data.close_price;
      s1_use_f_r <= bars_seen_r >= {1'b0, fw_r};
      s1_use_s_r <= bars_seen_r >= sw_r;
      s1_emit_r  <= bars_inc >= sw_r;
    end
  end

  // stage 2: window sums and price split by 10000
  assign px_prod = mactt_pkg::PX_PROD_W'(s1_px_r) * mactt_pkg::PX_PROD_W'(mactt_pkg::RECIP_PX);

  always_ff @(posedge clk) begin
    if (!rst_n || win_clear) begin
      fast_sum_r <= '0;
      slow_sum_r <= '0;
    end else if (mv[1]) begin
      fast_sum_r <= fast_sum_r + SUM_W'(s1_px_r) - (s1_use_f_r ? SUM_W'(rd_f_r) : '0);
      slow_sum_r <= slow_sum_r + SUM_W'(s1_px_r) - (s1_use_s_r ? SUM_W'(rd_s_r) : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (mv[1]) begin
      s2_ts_r <= s1_ts_r;
      s2_px_r <= s1_px_r;
      s2_ph_r <= px_prod[mactt_pkg::PX_PROD_W-1:mactt_pkg::RECIP_PX_SHIFT];
    end
  end

  // stage 3: cross products of the averages, price remainder
  always_comb begin
    ph_scaled = (mactt_pkg::PRICE_W+1)'(s2_ph_r) * (mactt_pkg::PRICE_W+1)'(mactt_pkg::BPS_ONE);
    pl_full   = (mactt_pkg::PRICE_W+1)'(s2_px_r) - ph_scaled;
  end

  always_ff @(posedge clk) begin
    if (mv[2]) begin
      s3_ts_r <= s2_ts_r;
      s3_px_r <= s2_px_r;
      s3_ph_r <= s2_ph_r;
      s3_pl_r <= pl_full[mactt_pkg::PL_W-1:0];
      s3_pf_r <= PROD_W'(fast_sum_r) * PROD_W'(sw_r);
      s3_ps_r <= PROD_W'(slow_sum_r) * PROD_W'(fw_r);
    end
  end

  // stage 4: crossover decision, fee partial products
  always_comb begin
    trade_nxt = mactt_pkg::TRADE_NONE;
    pos_nxt   = pos_r;
    priority if (s3_pf_r > s3_ps_r && !pos_r) begin
      trade_nxt = mactt_pkg::TRADE_BUY;
      pos_nxt   = 1'b1;
    end else if (s3_pf_r < s3_ps_r && pos_r) begin
      trade_nxt = mactt_pkg::TRADE_SELL;
      pos_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 1'b0;
    end else if (mv[3]) begin
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mv[3]) begin
      s4_ts_r    <= s3_ts_r;
      s4_px_r    <= s3_px_r;
      s4_hold_r  <= pos_nxt;
      s4_trade_r <= trade_nxt;
      s4_qa_r    <= mactt_pkg::QA_W'(s3_ph_r) * mactt_pkg::QA_W'(bps_sum);
      s4_wb_r    <= mactt_pkg::WB_W'(s3_pl_r) * mactt_pkg::WB_W'(bps_sum);
    end
  end

  // stage 5: remainder over 10000, truncated and rounded up
  always_comb begin
    lo_prod = mactt_pkg::REM_PROD_W'(s4_wb_r) *
              mactt_pkg::REM_PROD_W'(mactt_pkg::RECIP_REM);
    hi_prod = mactt_pkg::REM_PROD_W'(s4_wb_r + mactt_pkg::ROUND_UP) *
              mactt_pkg::REM_PROD_W'(mactt_pkg::RECIP_REM);
  end

  always_ff @(posedge clk) begin
    if (mv[4]) begin
      s5_ts_r    <= s4_ts_r;
      s5_px_r    <= s4_px_r;
      s5_hold_r  <= s4_hold_r;
      s5_trade_r <= s4_trade_r;
      s5_qa_r    <= s4_qa_r;
      s5_qlo_r   <= lo_prod[mactt_pkg::REM_PROD_W-1:mactt_pkg::RECIP_REM_SHIFT];
      s5_qhi_r   <= hi_prod[mactt_pkg::REM_PROD_W-1:mactt_pkg::RECIP_REM_SHIFT];
    end
  end

  // stage 6: signed cash change of the trade
  always_comb begin
    trade_amt = '0;
    delta_nxt = '0;
    unique case (s5_trade_r)
      mactt_pkg::TRADE_BUY: begin
        trade_amt = mactt_pkg::DELTA_W'(s5_px_r) + mactt_pkg::DELTA_W'(s5_qa_r) +
                    mactt_pkg::DELTA_W'(s5_qlo_r);
        delta_nxt = '0 - trade_amt;
      end
      mactt_pkg::TRADE_SELL: begin
        // costs up to one full unit round the charge up, beyond it truncates
        trade_amt = mactt_pkg::DELTA_W'(s5_qa_r) +
                    ((bps_sum <= mactt_pkg::BPS_ONE_V) ?
                     mactt_pkg::DELTA_W'(s5_qhi_r) : mactt_pkg::DELTA_W'(s5_qlo_r));
        delta_nxt = mactt_pkg::DELTA_W'(s5_px_r) - trade_amt;
      end
      default: begin
        trade_amt = '0;
        delta_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mv[5]) begin
      s6_ts_r    <= s5_ts_r;
      s6_px_r    <= s5_px_r;
      s6_hold_r  <= s5_hold_r;
      s6_delta_r <= delta_nxt;
    end
  end

  // stage 7: saturating cash balance
  always_comb begin
    cash_sum = {cash_r[mactt_pkg::EQ_W-1], cash_r} +
               {{(mactt_pkg::EQ_W+1-mactt_pkg::DELTA_W){s6_delta_r[mactt_pkg::DELTA_W-1]}},
                s6_delta_r};
    if (cash_sum[mactt_pkg::EQ_W] != cash_sum[mactt_pkg::EQ_W-1]) begin
      cash_nxt = cash_sum[mactt_pkg::EQ_W] ? mactt_pkg::EQ_MIN : mactt_pkg::EQ_MAX;
    end else begin
      cash_nxt = cash_sum[mactt_pkg::EQ_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cash_r <= '0;
    end else if (mv[6]) begin
      cash_r <= cash_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mv[6]) begin
      s7_ts_r   <= s6_ts_r;
      s7_px_r   <= s6_px_r;
      s7_hold_r <= s6_hold_r;
    end
  end

  // stage 8: saturating equity
  always_comb begin
    eq_sum = {cash_r[mactt_pkg::EQ_W-1], cash_r} +
             (s7_hold_r ? (mactt_pkg::EQ_W+1)'(s7_px_r) : '0);
    if (eq_sum[mactt_pkg::EQ_W] != eq_sum[mactt_pkg::EQ_W-1]) begin
      eq_nxt = eq_sum[mactt_pkg::EQ_W] ? mactt_pkg::EQ_MIN : mactt_pkg::EQ_MAX;
    end else begin
      eq_nxt = eq_sum[mactt_pkg::EQ_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mv[7]) begin
      s8_ts_r   <= s7_ts_r;
      s8_px_r   <= s7_px_r;
      s8_hold_r <= s7_hold_r;
      s8_eq_r   <= eq_nxt;
    end
  end

  // stage 9: running equity peak, starts at zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r <= '0;
    end else if (mv[8] && (s8_eq_r > peak_r)) begin
      peak_r <= s8_eq_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mv[8]) begin
      s9_ts_r   <= s8_ts_r;
      s9_px_r   <= s8_px_r;
      s9_hold_r <= s8_hold_r;
      s9_eq_r   <= s8_eq_r;
    end
  end

  // output stage: drawdown from peak, worst so far
  always_comb begin
    dd_full   = {peak_r[mactt_pkg::EQ_W-1], peak_r} - {s9_eq_r[mactt_pkg::EQ_W-1], s9_eq_r};
    dd_clip   = (dd_full[mactt_pkg::EQ_W:mactt_pkg::DD_W] != '0) ?
                mactt_pkg::DD_MAX : dd_full[mactt_pkg::DD_W-1:0];
    worst_nxt = (dd_clip > worst_r) ? dd_clip : worst_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      worst_r <= '0;
    end else if (mv[9]) begin
      worst_r <= worst_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mv[9]) begin
      out_data_r.point_time_ms <= s9_ts_r;
      out_data_r.point_price   <= s9_px_r;
      out_data_r.equity        <= s9_eq_r;
      out_data_r.holding       <= s9_hold_r;
      out_data_r.max_drawdown  <= worst_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // worst drawdown never shrinks
  a_worst_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> worst_r >= $past(worst_r))
    else $error("worst drawdown decreased");

  // fill count stays within the slow window
  a_bars_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bars_seen_r <= sw_r)
    else $error("bar count beyond slow window");

  // peak starts at zero and only rises
  a_peak_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    !peak_r[mactt_pkg::EQ_W-1])
    else $error("negative equity peak");

  // input held back only by a blocked first stage
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> v_r[1] && s1_emit_r && v_r[2])
    else $error("input stalled with room in the first stage");

endmodule

`default_nettype wire

[tb/sv/tb_ma_crossover_trade_tracker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ma_crossover_trade_tracker: self-checking bench of the crossover tracker
// a directed plan of bars and register writes, then random phases of trending
// and noisy prices under several window and cost settings; every curve point
// is checked field by field against a bit-true model of the tracker
// ----------------------------------------------------------------------------

module tb_ma_crossover_trade_tracker;
  import mactt_pkg::*;

  localparam int     NUM_PHASES   = 14;
  localparam int     DRAIN_CYCLES = 24;
  localparam longint RUN_LIMIT_NS = 5_000_000;
  localparam longint PX_TOP       = 64'h0000_0000_FFFF_FFFF;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  // one line of the directed plan: a register write or a bar
  typedef struct {
    bit                    is_cfg;
    cfg_reg_t              reg_id;
    logic [CFG_DATA_W-1:0] reg_val;
    in_item_t              bar;
    bit                    typed;
    out_item_t             point;
  } plan_row_t;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  ma_crossover_trade_tracker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // tracker model state, reset values
  logic [PRICE_W-1:0] ring_px [256];
  logic [7:0]         ring_wr     = '0;
  int unsigned        bars_in     = 0;
  logic [63:0]        fast_acc    = '0;
  logic [63:0]        slow_acc    = '0;
  bit                 holding_now = 1'b0;
  longint             cash_now    = 0;
  longint             peak_now    = 0;
  logic [63:0]        worst_dd    = '0;
  logic [FW_W-1:0]    fast_len    = FAST_RESET;
  logic [SW_W-1:0]    slow_len    = SLOW_RESET;
  logic [BPS_W-1:0]   fee_now     = '0;
  logic [BPS_W-1:0]   slip_now    = '0;

  out_item_t   curve_q [$];
  plan_row_t   plan [$];
  int unsigned mismatches = 0;

  // price walk of the random bars
  logic [TIME_W-1:0] clock_ms  = '0;
  longint            walk_px   = 1_000_000;
  int                trend     = 1;
  int unsigned       step_max  = 16;
  int unsigned       flip_odds = 6;

  // receiver stall pattern
  stall_mode_t stall_mode = STALL_NONE;
  int unsigned stall_left = 0;
  int unsigned stall_tick = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #(RUN_LIMIT_NS);
    $display("TB_ERROR");
    $finish;
  end

  function automatic longint clamp_eq(longint v);
    if (v > longint'(EQ_MAX)) return longint'(EQ_MAX);
    if (v < longint'(EQ_MIN)) return longint'(EQ_MIN);
    return v;
  endfunction

  // register write as the tracker sees it
  function automatic void apply_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] v);
    case (r)
      CFG_FAST_WINDOW, CFG_SLOW_WINDOW: begin
        if (r == CFG_FAST_WINDOW) fast_len = v[FW_W-1:0];
        else slow_len = v[SW_W-1:0];
        // window change restarts both averages
        ring_wr  = '0;
        bars_in  = 0;
        fast_acc = '0;
        slow_acc = '0;
      end
      CFG_FEE_BPS:      fee_now  = v[BPS_W-1:0];
      CFG_SLIPPAGE_BPS: slip_now = v[BPS_W-1:0];
      default: ;
    endcase
  endfunction

  // one bar through the tracker; returns 1 when a curve point comes out
  function automatic bit crossover_step(input in_item_t b, output out_item_t pt);
    logic [63:0] px, drop_fast, drop_slow, cost, lhs, rhs, dd;
    longint      proceeds, eq;
    int unsigned fw, sw, bps;
    pt = '0;
    fw = fast_len;
    sw = slow_len;
    // bad windows: bar is dropped without touching state
    if (fw == 0 || fw >= sw || sw > 256) return 1'b0;
    px        = 64'(b.close_price);
    drop_fast = (bars_in >= fw) ? 64'(ring_px[8'(ring_wr - fw)]) : 64'd0;
    drop_slow = (bars_in >= sw) ? 64'(ring_px[8'(ring_wr - sw)]) : 64'd0;
    ring_px[ring_wr] = b.close_price;
    ring_wr  = ring_wr + 8'd1;
    fast_acc = fast_acc + px - drop_fast;
    slow_acc = slow_acc + px - drop_slow;
    if (bars_in < sw) bars_in++;
    if (bars_in < sw) return 1'b0;
    // exact average compare by cross products
    lhs = fast_acc * 64'(sw);
    rhs = slow_acc * 64'(fw);
    bps = fee_now + slip_now;
    if (lhs > rhs && !holding_now) begin
      cost        = px * 64'(BPS_ONE + bps) / 64'(BPS_ONE);
      cash_now    = clamp_eq(cash_now - longint'(cost));
      holding_now = 1'b1;
    end else if (lhs < rhs && holding_now) begin
      // costs above one whole unit make the sale pay out
      if (bps <= BPS_ONE) proceeds = longint'(px * 64'(BPS_ONE - bps) / 64'(BPS_ONE));
      else proceeds = -longint'(px * 64'(bps - BPS_ONE) / 64'(BPS_ONE));
      cash_now    = clamp_eq(cash_now + proceeds);
      holding_now = 1'b0;
    end
    // equity, peak and drawdown
    eq = clamp_eq(cash_now + (holding_now ? longint'(px) : longint'(0)));
    if (eq > peak_now) peak_now = eq;
    dd = 64'(peak_now - eq);
    if (dd > 64'(DD_MAX)) dd = 64'(DD_MAX);
    if (dd > worst_dd) worst_dd = dd;
    pt.point_time_ms = b.timestamp_ms;
    pt.point_price   = b.close_price;
    pt.equity        = 48'(eq);
    pt.holding       = holding_now;
    pt.max_drawdown  = 47'(worst_dd);
    return 1'b1;
  endfunction

  // plan rows
  function automatic plan_row_t cfg_row(cfg_reg_t r, int unsigned v);
    plan_row_t row;
    row.is_cfg  = 1'b1;
    row.reg_id  = r;
    row.reg_val = CFG_DATA_W'(v);
    row.bar     = '0;
    row.typed   = 1'b0;
    row.point   = '0;
    return row;
  endfunction

  function automatic plan_row_t bar_row(logic [TIME_W-1:0] ts, logic [PRICE_W-1:0] px);
    plan_row_t row;
    row.is_cfg           = 1'b0;
    row.reg_id           = CFG_FAST_WINDOW;
    row.reg_val          = '0;
    row.bar.timestamp_ms = ts;
    row.bar.close_price  = px;
    row.typed            = 1'b0;
    row.point            = '0;
    return row;
  endfunction

  function automatic plan_row_t point_row(logic [TIME_W-1:0] ts, logic [PRICE_W-1:0] px,
                                          logic [EQ_W-1:0] eq, logic hold,
                                          logic [DD_W-1:0] dd);
    plan_row_t row;
    row       = bar_row(ts, px);
    row.typed = 1'b1;
    row.point = {ts, px, eq, hold, dd};
    return row;
  endfunction

  // cost setting: zero, small, anywhere, or one whole unit
  function automatic int unsigned pick_bps();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return $urandom_range(0, 100);
      2:       return $urandom_range(0, BPS_ONE);
      default: return BPS_ONE;
    endcase
  endfunction

  // random bar: mostly a trending walk, some flat bars and some noise
  function automatic in_item_t next_bar();
    in_item_t b;
    longint   p;
    clock_ms       = clock_ms + TIME_W'($urandom_range(1, 60000));
    b.timestamp_ms = clock_ms;
    if ($urandom_range(0, 15) == 0) b.timestamp_ms = TIME_W'({$urandom, $urandom});
    if ($urandom_range(0, 9) == 0) begin
      b.close_price = PRICE_W'($urandom);
    end else begin
      if ($urandom_range(1, flip_odds) == 1) trend = -trend;
      p = walk_px;
      if ($urandom_range(0, 11) != 0) p = p + trend * longint'($urandom_range(0, step_max));
      if (p < 0) p = 0;
      if (p > PX_TOP) p = PX_TOP;
      walk_px       = p;
      b.close_price = PRICE_W'(p);
    end
    return b;
  endfunction

  // bar handshake; expectation is taken when the bar is accepted
  task automatic send_bar(in_item_t b, bit typed, out_item_t typed_pt);
    out_item_t pt;
    bit        got;
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_stall);
    got = crossover_step(b, pt);
    if (typed) curve_q.push_back(typed_pt);
    else if (got) curve_q.push_back(pt);
    @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, int unsigned v);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data  <= CFG_DATA_W'(v);
    do @(posedge clk); while (!cfg_ready);
    apply_reg(r, CFG_DATA_W'(v));
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // stop sending and let every pending point and in-flight bar drain
  task automatic settle();
    in_valid <= 1'b0;
    while (curve_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic check_field(string what, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch in %s: expected %0h, got %0h", what, want, got);
    end
  endtask

  // receiver stall pattern, picks a new random mode whenever its run ends
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        stall_left = $urandom_range(16, 96);
      end
      stall_left--;
      stall_tick++;
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 7) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= ((stall_tick % 5) < 2);
      endcase
    end
  end

  // curve point checker
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (curve_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("curve point with none pending: time %0h price %0h",
                   out_data.point_time_ms, out_data.point_price);
      end else begin
        want = curve_q.pop_front();
        check_field("point_time_ms", 64'(want.point_time_ms), 64'(out_data.point_time_ms));
        check_field("point_price", 64'(want.point_price), 64'(out_data.point_price));
        check_field("equity", 64'(want.equity), 64'(out_data.equity));
        check_field("holding", 64'(want.holding), 64'(out_data.holding));
        check_field("max_drawdown", 64'(want.max_drawdown), 64'(out_data.max_drawdown));
      end
    end
  end

  // stimulus
  initial begin : stimulus
    int unsigned ph, k, n_bars, burst_left, gap, fw;
    bit          steady;

    // directed plan
    // reset windows still filling: no points
    plan.push_back(bar_row(48'd5, 32'd100));
    plan.push_back(bar_row(48'd6, 32'h8000_0000));
    plan.push_back(bar_row(48'd7, 32'd200));
    plan.push_back(bar_row(48'd8, 32'd0));
    // shortest windows, zero cost
    plan.push_back(cfg_row(CFG_FAST_WINDOW, 1));
    plan.push_back(cfg_row(CFG_SLOW_WINDOW, 2));
    plan.push_back(bar_row(48'd0, 32'd0));
    // rise to full scale buys at full price
    plan.push_back(point_row(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 48'd0, 1'b1, 47'd0));
    // drop to zero sells for nothing
    plan.push_back(point_row(48'd1, 32'd0, 48'hFFFF_0000_0001, 1'b0, 47'h0000_FFFF_FFFF));
    // largest costs: sale pays out
    plan.push_back(cfg_row(CFG_FEE_BPS, BPS_ONE));
    plan.push_back(cfg_row(CFG_SLIPPAGE_BPS, BPS_ONE));
    plan.push_back(bar_row(48'd10, 32'd1000));
    plan.push_back(bar_row(48'd11, 32'd1000));
    plan.push_back(bar_row(48'd12, 32'd400));
    plan.push_back(bar_row(48'd13, 32'd400));
    // costs of exactly one unit: sale brings nothing
    plan.push_back(cfg_row(CFG_SLIPPAGE_BPS, 0));
    plan.push_back(bar_row(48'd14, 32'd900));
    plan.push_back(bar_row(48'd15, 32'd100));
    // small costs with truncation
    plan.push_back(cfg_row(CFG_FEE_BPS, 37));
    plan.push_back(cfg_row(CFG_SLIPPAGE_BPS, 13));
    plan.push_back(bar_row(48'd16, 32'd12345));
    plan.push_back(bar_row(48'd17, 32'd12344));
    // equal and inverted windows ignore bars
    plan.push_back(cfg_row(CFG_FAST_WINDOW, 2));
    plan.push_back(bar_row(48'd18, 32'd7));
    plan.push_back(cfg_row(CFG_FAST_WINDOW, 5));
    plan.push_back(cfg_row(CFG_SLOW_WINDOW, 3));
    plan.push_back(bar_row(48'd19, 32'd8));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        write_reg(plan[i].reg_id, plan[i].reg_val);
      end else begin
        send_bar(plan[i].bar, plan[i].typed, plan[i].point);
      end
    end

    // random phases
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      n_bars    = 0;
      flip_odds = 6;
      walk_px   = longint'($urandom);
      case ($urandom_range(0, 2))
        0:       step_max = 16;
        1:       step_max = 4000;
        default: step_max = 1 << 20;
      endcase
      if (ph == 1) begin
        write_reg(CFG_FAST_WINDOW, 1);
        write_reg(CFG_SLOW_WINDOW, 2);
      end else if (ph == 4) begin
        // longest windows and largest costs, slow trends
        write_reg(CFG_FAST_WINDOW, 255);
        write_reg(CFG_SLOW_WINDOW, 256);
        write_reg(CFG_FEE_BPS, BPS_ONE);
        write_reg(CFG_SLIPPAGE_BPS, BPS_ONE);
        flip_odds = 60;
        n_bars    = 320;
      end else if (ph == 7) begin
        // fast not below slow: all bars dropped
        fw = $urandom_range(2, 255);
        write_reg(CFG_FAST_WINDOW, fw);
        write_reg(CFG_SLOW_WINDOW, $urandom_range(2, fw));
        n_bars = 8;
      end else if (fast_len < slow_len && $urandom_range(0, 3) == 0) begin
        // costs only, averages keep running
        write_reg(CFG_FEE_BPS, pick_bps());
        write_reg(CFG_SLIPPAGE_BPS, pick_bps());
      end else begin
        fw = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 8);
        write_reg(CFG_FAST_WINDOW, fw);
        write_reg(CFG_SLOW_WINDOW, $urandom_range(fw + 1, fw + 16));
        write_reg(CFG_FEE_BPS, pick_bps());
        write_reg(CFG_SLIPPAGE_BPS, pick_bps());
      end
      if (n_bars == 0) n_bars = slow_len + $urandom_range(15, 45);

      steady     = ($urandom_range(0, 3) == 0);
      burst_left = 0;
      for (k = 0; k < n_bars; k++) begin
        // hold off mid-phase until the pipe is empty
        if (ph == 0 && k == n_bars / 2) settle();
        if (burst_left == 0) begin
          gap = steady ? 0 : $urandom_range(1, 8);
          if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
          end
          burst_left = $urandom_range(1, 24);
        end
        send_bar(next_bar(), 1'b0, '0);
        burst_left--;
      end
    end

    settle();
    if (mismatches == 0 && curve_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[ma_crossover_trade_tracker.f]
hdl/mactt_pkg.sv
hdl/ma_crossover_trade_tracker.sv
tb/sv/tb_ma_crossover_trade_tracker.sv
